// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the parser, queue and output-stage RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ----- rtl/ubxfr_pkg.sv -----
// ----------------------------------------------------------------------------
// ubxfr_pkg
// Shared constants and types of the UBX frame receiver: sync bytes, message
// keys, minimum payload lengths, and the result queue entry.
// ----------------------------------------------------------------------------
package ubxfr_pkg;

    localparam logic [7:0]  SYNC_FIRST   = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND  = 8'h62;
    localparam logic [15:0] KEY_POSITION = 16'h0102;
    localparam logic [15:0] KEY_VELOCITY = 16'h0112;

    localparam logic [15:0] CAPTURE_START    = 16'd16;
    localparam logic [15:0] CAPTURE_END      = 16'd36;
    localparam logic [15:0] MIN_LEN_POSITION = 16'd28;
    localparam logic [15:0] MIN_LEN_VELOCITY = 16'd36;

    localparam logic KIND_POSITION = 1'b0;
    localparam logic KIND_VELOCITY = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Payload words at offsets 16, 24, 28 and 32.
    typedef struct packed {
        logic        kind;
        logic [31:0] word16;
        logic [31:0] word24;
        logic [31:0] word28;
        logic [31:0] word32;
    } qentry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

endpackage

// ----- rtl/ubxfr_parser.sv -----
// ----------------------------------------------------------------------------
// ubxfr_parser
// Front end: walks the UBX frame byte by byte, keeps the Fletcher sums,
// captures the wanted payload words and pushes one entry per good frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ubxfr_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        rx_byte,
    output logic              push,
    output ubxfr_pkg::qentry_t entry
);

    localparam logic [3:0] PH_SYNC1   = 4'd0;
    localparam logic [3:0] PH_SYNC2   = 4'd1;
    localparam logic [3:0] PH_CLASS   = 4'd2;
    localparam logic [3:0] PH_IDENT   = 4'd3;
    localparam logic [3:0] PH_LEN_LO  = 4'd4;
    localparam logic [3:0] PH_LEN_HI  = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CK_A    = 4'd7;
    localparam logic [3:0] PH_CK_B    = 4'd8;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] idx_reg, idx_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  ident_reg, ident_next;
    logic [7:0]  ck_lo_reg, ck_lo_next;
    logic [31:0] w16_reg, w24_reg, w28_reg, w32_reg;

    logic [7:0]  acc_a;
    logic [7:0]  acc_b;
    logic [15:0] idx_inc;
    logic        in_window;
    logic [5:0]  rel;
    logic [2:0]  word_sel;
    logic [1:0]  lane;
    logic        cap_en;
    logic [15:0] key;
    logic        sum_ok;
    logic        push_next;

    assign acc_a     = sum_a_reg + rx_byte;
    assign acc_b     = sum_b_reg + acc_a;
    assign idx_inc   = idx_reg + 16'd1;
    assign in_window = (idx_reg >= ubxfr_pkg::CAPTURE_START)
                    && (idx_reg < ubxfr_pkg::CAPTURE_END);
    assign rel       = idx_reg[5:0] - ubxfr_pkg::CAPTURE_START[5:0];
    assign word_sel  = rel[4:2];
    assign lane      = rel[1:0];
    assign cap_en    = take && (phase_reg == PH_PAYLOAD) && in_window;
    assign key       = {class_reg, ident_reg};
    assign sum_ok    = (ck_lo_reg == sum_a_reg) && (rx_byte == sum_b_reg);

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        class_next = class_reg;
        ident_next = ident_reg;
        ck_lo_next = ck_lo_reg;
        push_next  = 1'b0;
        case (phase_reg)
            PH_SYNC2:
            begin
                phase_next = (rx_byte == ubxfr_pkg::SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS:
            begin
                sum_a_next = rx_byte;
                sum_b_next = rx_byte;
                class_next = rx_byte;
                phase_next = PH_IDENT;
            end
            PH_IDENT:
            begin
                sum_a_next = acc_a;
                sum_b_next = acc_b;
                ident_next = rx_byte;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                sum_a_next = acc_a;
                sum_b_next = acc_b;
                len_next   = {8'd0, rx_byte};
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                sum_a_next = acc_a;
                sum_b_next = acc_b;
                len_next   = {rx_byte, len_reg[7:0]};
                idx_next   = 16'd0;
                phase_next = ({rx_byte, len_reg[7:0]} == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                sum_a_next = acc_a;
                sum_b_next = acc_b;
                idx_next   = idx_inc;
                if (idx_inc == len_reg)
                begin
                    phase_next = PH_CK_A;
                end
            end
            PH_CK_A:
            begin
                ck_lo_next = rx_byte;
                phase_next = PH_CK_B;
            end
            PH_CK_B:
            begin
                if (sum_ok)
                begin
                    if (key == ubxfr_pkg::KEY_POSITION && len_reg >= ubxfr_pkg::MIN_LEN_POSITION)
                    begin
                        push_next = 1'b1;
                    end
                    else if (key == ubxfr_pkg::KEY_VELOCITY
                             && len_reg >= ubxfr_pkg::MIN_LEN_VELOCITY)
                    begin
                        push_next = 1'b1;
                    end
                end
                phase_next = PH_SYNC1;
            end
            default:
            begin
                phase_next = (rx_byte == ubxfr_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            len_reg   <= 16'd0;
            idx_reg   <= 16'd0;
            sum_a_reg <= 8'd0;
            sum_b_reg <= 8'd0;
            class_reg <= 8'd0;
            ident_reg <= 8'd0;
            ck_lo_reg <= 8'd0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            class_reg <= class_next;
            ident_reg <= ident_next;
            ck_lo_reg <= ck_lo_next;
        end
    end

    // Every word a result reads is fully rewritten by a long-enough frame.
    always_ff @(posedge clk)
    begin
        if (cap_en)
        begin
            case (word_sel)
                3'd0:    w16_reg[lane*8 +: 8] <= rx_byte;
                3'd2:    w24_reg[lane*8 +: 8] <= rx_byte;
                3'd3:    w28_reg[lane*8 +: 8] <= rx_byte;
                3'd4:    w32_reg[lane*8 +: 8] <= rx_byte;
                default: ;
            endcase
        end
    end

    assign push         = take && push_next;
    assign entry.kind   = (ident_reg == ubxfr_pkg::KEY_VELOCITY[7:0])
                          ? ubxfr_pkg::KIND_VELOCITY : ubxfr_pkg::KIND_POSITION;
    assign entry.word16 = w16_reg;
    assign entry.word24 = w24_reg;
    assign entry.word28 = w28_reg;
    assign entry.word32 = w32_reg;

    `ASSERT_IMPLIES(a_push_at_ckb, clk, rst_n, push, (phase_reg == PH_CK_B) && sum_ok)

endmodule

// ----- rtl/ubxfr_queue.sv -----
// ----------------------------------------------------------------------------
// ubxfr_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ubxfr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ubxfr_pkg::qentry_t push_entry,
    input  logic               pop,
    output ubxfr_pkg::qentry_t head,
    output ubxfr_pkg::qstat_t  stat
);

    localparam logic [ubxfr_pkg::Q_PTR_W-1:0] PTR_LAST =
        ubxfr_pkg::Q_PTR_W'(ubxfr_pkg::QUEUE_DEPTH - 1);
    localparam logic [ubxfr_pkg::Q_CNT_W-1:0] CNT_FULL =
        ubxfr_pkg::Q_CNT_W'(ubxfr_pkg::QUEUE_DEPTH);

    ubxfr_pkg::qentry_t mem [ubxfr_pkg::QUEUE_DEPTH];

    logic [ubxfr_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ubxfr_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ubxfr_pkg::Q_CNT_W-1:0] count_reg, count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_FULL);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    `ASSERT_IMPLIES(a_no_push_full, clk, rst_n, push, !stat.full)
    `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, pop, !stat.empty)

endmodule

// ----- rtl/ubxfr_out.sv -----
// ----------------------------------------------------------------------------
// ubxfr_out
// Back end: pops a queue entry, maps the words onto the result fields by
// message kind, and holds the result until the downstream takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ubxfr_out (
    input  logic               clk,
    input  logic               rst_n,
    input  ubxfr_pkg::qentry_t head,
    input  ubxfr_pkg::qstat_t  stat,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               msg_kind,
    output logic signed [31:0] msl_height_mm,
    output logic [31:0]        vert_acc_mm,
    output logic [31:0]        speed_3d_cms,
    output logic [31:0]        speed_acc_cms,
    output logic signed [31:0] heading_e5_deg,
    output logic [31:0]        heading_accuracy_e5_deg
);

    logic        valid_reg;
    logic        kind_reg;
    logic [31:0] alt_reg, alt_acc_reg, spd_reg, spd_acc_reg, hdg_reg, hdg_acc_reg;
    logic        is_vel;

    // Load whenever an entry waits and the output register is empty or its transfer completes.
    assign pop    = !stat.empty && (!valid_reg || !out_stall);
    assign is_vel = (head.kind == ubxfr_pkg::KIND_VELOCITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg    <= head.kind;
            alt_reg     <= is_vel ? 32'd0 : head.word16;
            alt_acc_reg <= is_vel ? 32'd0 : head.word24;
            spd_reg     <= is_vel ? head.word16 : 32'd0;
            spd_acc_reg <= is_vel ? head.word28 : 32'd0;
            hdg_reg     <= is_vel ? head.word24 : 32'd0;
            hdg_acc_reg <= is_vel ? head.word32 : 32'd0;
        end
    end

    assign out_valid               = valid_reg;
    assign msg_kind                = kind_reg;
    assign msl_height_mm           = alt_reg;
    assign vert_acc_mm             = alt_acc_reg;
    assign speed_3d_cms            = spd_reg;
    assign speed_acc_cms           = spd_acc_reg;
    assign heading_e5_deg          = hdg_reg;
    assign heading_accuracy_e5_deg = hdg_acc_reg;

    `ASSERT_NEXT(a_pop_loads, clk, rst_n, pop, valid_reg)

endmodule

// ----- rtl/ubx_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// ubx_frame_receiver
// Parses UBX frames from a byte stream and reports checked position-height
// and velocity messages.
// ----------------------------------------------------------------------------
//   channel   handshake             payload
//   input     in_valid / in_stall   rx_byte
//   output    out_valid / out_stall msg_kind, msl_height_mm, vert_acc_mm,
//                                   speed_*, heading_*
//
// One byte is taken every cycle in which in_valid is high and the result queue has room.
// After a good frame's last checksum byte is taken, its entry is written into the queue and then
// loaded into the output register, which raises out_valid; a stalled output can delay the load.
// in_stall rises only when the two-entry result queue is full.
// rst_n clears the parser state, the queue pointers and the output valid.
// ----------------------------------------------------------------------------
module ubx_frame_receiver (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               msg_kind,
    output logic signed [31:0] msl_height_mm,
    output logic [31:0]        vert_acc_mm,
    output logic [31:0]        speed_3d_cms,
    output logic [31:0]        speed_acc_cms,
    output logic signed [31:0] heading_e5_deg,
    output logic [31:0]        heading_accuracy_e5_deg
);

    logic               take;
    logic               push;
    logic               pop;
    ubxfr_pkg::qentry_t push_entry;
    ubxfr_pkg::qentry_t head;
    ubxfr_pkg::qstat_t  stat;

    assign in_stall = stat.full;
    assign take     = in_valid && !stat.full;

    ubxfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .push    (push),
        .entry   (push_entry)
    );

    ubxfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (stat)
    );

    ubxfr_out u_out (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .head                    (head),
        .stat                    (stat),
        .pop                     (pop),
        .out_valid               (out_valid),
        .out_stall               (out_stall),
        .msg_kind                (msg_kind),
        .msl_height_mm           (msl_height_mm),
        .vert_acc_mm             (vert_acc_mm),
        .speed_3d_cms            (speed_3d_cms),
        .speed_acc_cms           (speed_acc_cms),
        .heading_e5_deg          (heading_e5_deg),
        .heading_accuracy_e5_deg (heading_accuracy_e5_deg)
    );

endmodule
